>>> hw/rtl/lfu_page_replacement_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the LFU page replacement block
// Shared clocked property forms, reset-qualified on aresetn.
// ----------------------------------------------------------------------------
`ifndef LFU_PAGE_REPLACEMENT_TOP_MACROS_SVH
`define LFU_PAGE_REPLACEMENT_TOP_MACROS_SVH

// same-cycle implication
`define LFU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LFU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/lfu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_pkg
// Types and constants shared by the LFU page replacement block.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int LFU_FRAMES    = 8;
    localparam int LFU_PAGE_BITS = 16;

    localparam int PAGE_W  = 16;
    localparam int CFG_W   = 4;
    localparam int CNT_W   = 16;
    localparam int STAMP_W = 32;
    localparam int TOT_W   = 32;
    localparam int SLOT_W  = 3;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              start_sequence;
    } lfu_in_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted_valid;
        logic [PAGE_W-1:0] evicted_page;
        logic [TOT_W-1:0]  miss_total;
        logic [TOT_W-1:0]  hit_total;
    } lfu_out_t;

    // write-back command broadcast to every cell
    typedef struct packed {
        logic               clear;
        logic               bump;
        logic               fill;
        logic [STAMP_W-1:0] stamp;
    } lfu_cmd_t;

    // scan record flags handed from cell to cell
    typedef struct packed {
        logic found;
        logic empty_found;
        logic have_vic;
    } lfu_flags_t;

endpackage

>>> hw/rtl/lfu_page_replacement_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_page_replacement_top
// LFU page replacement with arrival-order tie-break over a chain of frames.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat is one page reference; start_sequence set in the
//   beat clears all frames, use counts, stamps and totals first.
//   m_ channel: one result beat per reference (hit, slot, eviction, totals).
//   cfg_wr_en/cfg_wr_data: frames_in_use, to be written by the user only
//   while idle (not enforced); 0 acts as 1 and values above FRAMES act as FRAMES.
// Timing: the accept edge takes the beat (and clears, if asked), then the
//   scan record walks down the cell chain one cell per cycle, and a
//   write-back step loads the result register. One reference is in flight
//   at a time and s_ready returns the cycle after the write-back, so no
//   new reference is taken before the last one is written back.
// Stall: a result waits in the output register while m_ready is low; the
//   next beat is still taken and scanned, and its write-back holds until
//   the output register frees.
// Reset: all frames empty, counts, stamps and totals zero, frames_in_use 8.
// ----------------------------------------------------------------------------
module lfu_page_replacement_top #(
    parameter int FRAMES    = lfu_pkg::LFU_FRAMES,
    parameter int PAGE_BITS = lfu_pkg::LFU_PAGE_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [lfu_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  lfu_pkg::lfu_in_t          s_payload,
    output logic                      m_valid,
    input  logic                      m_ready,
    output lfu_pkg::lfu_out_t         m_payload
);
    import lfu_pkg::*;

    localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int PW     = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
    localparam int NCNT_W = $clog2(FRAMES + 1);
    localparam int CMP_W  = (NCNT_W > CFG_W) ? NCNT_W : CFG_W;

    // control states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [IDX_W-1:0]   step_reg,  step_next;
    logic [CFG_W-1:0]   cfg_reg;
    logic [PW-1:0]      pg_reg;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    logic [TOT_W-1:0]   miss_reg,  miss_next;
    logic [TOT_W-1:0]   hits_reg,  hits_next;
    logic               m_valid_reg, m_valid_next;
    lfu_out_t           out_reg,   out_next;

    logic               accept;
    logic               fire;
    logic [CMP_W-1:0]   cfg_ext;
    logic [CMP_W-1:0]   n_act;
    lfu_cmd_t           cmd;
    logic [IDX_W-1:0]   sel_idx;
    logic               found;
    logic               empty_found;

    // scan chain taps, one per cell
    lfu_flags_t         flags_q   [FRAMES];
    logic [IDX_W-1:0]   hit_idx_q [FRAMES];
    logic [IDX_W-1:0]   empty_q   [FRAMES];
    logic [IDX_W-1:0]   vic_idx_q [FRAMES];
    logic [CNT_W-1:0]   vic_cnt_q [FRAMES];
    logic [STAMP_W-1:0] vic_stp_q [FRAMES];
    logic [PW-1:0]      vic_pg_q  [FRAMES];

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign fire    = (state_reg == ST_WRITE) && (!m_valid_reg || m_ready);

    // clamp the active frame count
    assign cfg_ext = CMP_W'(cfg_reg);
    always_comb begin
        if (cfg_reg == '0) begin
            n_act = CMP_W'(1);
        end else if (cfg_ext > CMP_W'(FRAMES)) begin
            n_act = CMP_W'(FRAMES);
        end else begin
            n_act = cfg_ext;
        end
    end

    // end-of-chain record
    assign found       = flags_q[FRAMES-1].found;
    assign empty_found = flags_q[FRAMES-1].empty_found;

    always_comb begin
        if (found) begin
            sel_idx = hit_idx_q[FRAMES-1];
        end else if (empty_found) begin
            sel_idx = empty_q[FRAMES-1];
        end else begin
            sel_idx = vic_idx_q[FRAMES-1];
        end
    end

    // write-back command: clear on a start beat, bump or fill on fire
    always_comb begin
        cmd.clear = accept && s_payload.start_sequence;
        cmd.bump  = fire && found;
        cmd.fill  = fire && !found;
        cmd.stamp = stamp_reg;
    end

    genvar k;
    generate
        for (k = 0; k < FRAMES; k++) begin : g_cell
            lfu_flags_t         f_in;
            logic [IDX_W-1:0]   h_in, e_in, v_in;
            logic [CNT_W-1:0]   c_in;
            logic [STAMP_W-1:0] t_in;
            logic [PW-1:0]      p_in;

            if (k == 0) begin : g_head
                assign f_in = '0;
                assign h_in = '0;
                assign e_in = '0;
                assign v_in = '0;
                assign c_in = '0;
                assign t_in = '0;
                assign p_in = '0;
            end else begin : g_link
                assign f_in = flags_q[k-1];
                assign h_in = hit_idx_q[k-1];
                assign e_in = empty_q[k-1];
                assign v_in = vic_idx_q[k-1];
                assign c_in = vic_cnt_q[k-1];
                assign t_in = vic_stp_q[k-1];
                assign p_in = vic_pg_q[k-1];
            end

            lfu_cell #(
                .IDX_W    (IDX_W),
                .PW       (PW),
                .CELL_IDX (k)
            ) u_cell (
                .aclk          (aclk),
                .aresetn       (aresetn),
                .step_en       ((state_reg == ST_SCAN) && (step_reg == IDX_W'(k))),
                .active        (CMP_W'(k) < n_act),
                .sel           (sel_idx == IDX_W'(k)),
                .cmd           (cmd),
                .page          (pg_reg),
                .flags_in      (f_in),
                .hit_idx_in    (h_in),
                .empty_idx_in  (e_in),
                .vic_idx_in    (v_in),
                .vic_cnt_in    (c_in),
                .vic_stamp_in  (t_in),
                .vic_page_in   (p_in),
                .flags_out     (flags_q[k]),
                .hit_idx_out   (hit_idx_q[k]),
                .empty_idx_out (empty_q[k]),
                .vic_idx_out   (vic_idx_q[k]),
                .vic_cnt_out   (vic_cnt_q[k]),
                .vic_stamp_out (vic_stp_q[k]),
                .vic_page_out  (vic_pg_q[k])
            );
        end
    endgenerate

    // sequencer, counters and result register
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        stamp_next   = stamp_reg;
        miss_next    = miss_reg;
        hits_next    = hits_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;

        // drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SCAN;
                    step_next  = '0;
                    if (s_payload.start_sequence) begin
                        stamp_next = '0;
                        miss_next  = '0;
                        hits_next  = '0;
                    end
                end
            end
            ST_SCAN: begin
                // advance the record one cell per cycle
                if (step_reg == IDX_W'(FRAMES - 1)) begin
                    state_next = ST_WRITE;
                end else begin
                    step_next = step_reg + IDX_W'(1);
                end
            end
            ST_WRITE: begin
                if (fire) begin
                    if (found) begin
                        if (hits_reg != {TOT_W{1'b1}}) begin
                            hits_next = hits_reg + TOT_W'(1);
                        end
                    end else begin
                        if (stamp_reg != {STAMP_W{1'b1}}) begin
                            stamp_next = stamp_reg + STAMP_W'(1);
                        end
                        if (miss_reg != {TOT_W{1'b1}}) begin
                            miss_next = miss_reg + TOT_W'(1);
                        end
                    end
                    out_next.hit           = found;
                    out_next.slot          = SLOT_W'(sel_idx);
                    out_next.evicted_valid = !found && !empty_found;
                    out_next.evicted_page  = (!found && !empty_found) ?
                                             PAGE_W'(vic_pg_q[FRAMES-1]) : '0;
                    out_next.miss_total    = miss_next;
                    out_next.hit_total     = hits_next;
                    m_valid_next           = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            cfg_reg     <= CFG_RESET;
            stamp_reg   <= '0;
            miss_reg    <= '0;
            hits_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            stamp_reg   <= stamp_next;
            miss_reg    <= miss_next;
            hits_reg    <= hits_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (accept) begin
            pg_reg <= s_payload.page[PW-1:0];
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

endmodule

>>> hw/rtl/lfu_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cell
// One page frame plus one stage of the scan chain.
// ----------------------------------------------------------------------------
module lfu_cell #(
    parameter int IDX_W    = 3,
    parameter int PW       = 16,
    parameter int CELL_IDX = 0
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step_en,
    input  logic                        active,
    input  logic                        sel,
    input  lfu_pkg::lfu_cmd_t           cmd,
    input  logic [PW-1:0]               page,
    input  lfu_pkg::lfu_flags_t         flags_in,
    input  logic [IDX_W-1:0]            hit_idx_in,
    input  logic [IDX_W-1:0]            empty_idx_in,
    input  logic [IDX_W-1:0]            vic_idx_in,
    input  logic [lfu_pkg::CNT_W-1:0]   vic_cnt_in,
    input  logic [lfu_pkg::STAMP_W-1:0] vic_stamp_in,
    input  logic [PW-1:0]               vic_page_in,
    output lfu_pkg::lfu_flags_t         flags_out,
    output logic [IDX_W-1:0]            hit_idx_out,
    output logic [IDX_W-1:0]            empty_idx_out,
    output logic [IDX_W-1:0]            vic_idx_out,
    output logic [lfu_pkg::CNT_W-1:0]   vic_cnt_out,
    output logic [lfu_pkg::STAMP_W-1:0] vic_stamp_out,
    output logic [PW-1:0]               vic_page_out
);
    import lfu_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [PW-1:0]      page_reg;
    logic               valid_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [STAMP_W-1:0] stamp_reg;

    lfu_flags_t         flags_reg,     flags_next;
    logic [IDX_W-1:0]   hit_idx_reg,   hit_idx_next;
    logic [IDX_W-1:0]   empty_idx_reg, empty_idx_next;
    logic [IDX_W-1:0]   vic_idx_reg,   vic_idx_next;
    logic [CNT_W-1:0]   vic_cnt_reg,   vic_cnt_next;
    logic [STAMP_W-1:0] vic_stamp_reg, vic_stamp_next;
    logic [PW-1:0]      vic_page_reg,  vic_page_next;

    logic better;

    // fold this frame into the passing record
    always_comb begin
        flags_next     = flags_in;
        hit_idx_next   = hit_idx_in;
        empty_idx_next = empty_idx_in;
        vic_idx_next   = vic_idx_in;
        vic_cnt_next   = vic_cnt_in;
        vic_stamp_next = vic_stamp_in;
        vic_page_next  = vic_page_in;
        better = !flags_in.have_vic || (cnt_reg < vic_cnt_in) ||
                 ((cnt_reg == vic_cnt_in) && (stamp_reg < vic_stamp_in));
        if (active) begin
            if (!flags_in.found && valid_reg && (page_reg == page)) begin
                flags_next.found = 1'b1;
                hit_idx_next     = MY_IDX;
            end
            if (!flags_in.empty_found && !valid_reg) begin
                flags_next.empty_found = 1'b1;
                empty_idx_next         = MY_IDX;
            end
            if (better) begin
                flags_next.have_vic = 1'b1;
                vic_idx_next        = MY_IDX;
                vic_cnt_next        = cnt_reg;
                vic_stamp_next      = stamp_reg;
                vic_page_next       = page_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else if (step_en) begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            hit_idx_reg   <= hit_idx_next;
            empty_idx_reg <= empty_idx_next;
            vic_idx_reg   <= vic_idx_next;
            vic_cnt_reg   <= vic_cnt_next;
            vic_stamp_reg <= vic_stamp_next;
            vic_page_reg  <= vic_page_next;
        end
    end

    // frame contents
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            page_reg  <= '0;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
            stamp_reg <= '0;
        end else if (sel && cmd.bump) begin
            if (cnt_reg != {CNT_W{1'b1}}) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end else if (sel && cmd.fill) begin
            page_reg  <= page;
            valid_reg <= 1'b1;
            cnt_reg   <= CNT_W'(1);
            stamp_reg <= cmd.stamp;
        end
    end

    assign flags_out     = flags_reg;
    assign hit_idx_out   = hit_idx_reg;
    assign empty_idx_out = empty_idx_reg;
    assign vic_idx_out   = vic_idx_reg;
    assign vic_cnt_out   = vic_cnt_reg;
    assign vic_stamp_out = vic_stamp_reg;
    assign vic_page_out  = vic_page_reg;

endmodule

>>> hw/rtl/lfu_page_replacement_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_page_replacement_chk
// Port-level checks for the LFU page replacement block, bound to the top.
// ----------------------------------------------------------------------------
`include "lfu_page_replacement_top_macros.svh"

module lfu_page_replacement_chk (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      cfg_wr_en,
    input logic [lfu_pkg::CFG_W-1:0] cfg_wr_data,
    input logic                      s_valid,
    input logic                      s_ready,
    input lfu_pkg::lfu_in_t          s_payload,
    input logic                      m_valid,
    input logic                      m_ready,
    input lfu_pkg::lfu_out_t         m_payload
);
    import lfu_pkg::*;

    // a stalled result beat holds
    `LFU_ASSERT_NEXT(a_out_hold, m_valid && !m_ready,
        m_valid && $stable(m_payload), "result beat changed while stalled")

    // one reference in flight: busy right after an accept
    `LFU_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready,
        !s_ready, "input taken while a reference is in flight")

    // a hit never evicts
    `LFU_ASSERT_NOW(a_hit_no_evict, m_valid && m_payload.hit,
        !m_payload.evicted_valid, "hit reported with an eviction")

    // no eviction means a zero evicted page
    `LFU_ASSERT_NOW(a_evict_page_zero, m_valid && !m_payload.evicted_valid,
        m_payload.evicted_page == '0, "evicted page set without eviction")

endmodule

bind lfu_page_replacement_top lfu_page_replacement_chk u_chk (.*);
